// File: src/cht_pkg.sv
// Package: shared types and constants of the combination hold trigger.
`timescale 1ns / 1ps
package cht_pkg;

    localparam int KEY_W   = 16;
    localparam int CFG_W   = 16;
    localparam int PHASE_W = 2;

    localparam int KEY_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_COMBO_KEYS      = 2'd0;
    localparam logic [1:0] CFG_HOLD_SAMPLES    = 2'd1;
    localparam logic [1:0] CFG_RELEASE_SAMPLES = 2'd2;

    // reset values: keys 0 and 5, 300 ms and 200 ms at a 10 ms poll
    localparam logic [CFG_W-1:0] COMBO_KEYS_RST      = CFG_W'((1 << 0) | (1 << 5));
    localparam logic [CFG_W-1:0] HOLD_SAMPLES_RST    = CFG_W'(300 / 10);
    localparam logic [CFG_W-1:0] RELEASE_SAMPLES_RST = CFG_W'(200 / 10);

    // reported phase of a launched task still running
    localparam logic [PHASE_W-1:0] PHASE_BUSY = 2'd2;

    // input kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] keys;
    } cht_in_t;

    typedef struct packed {
        logic               fire;
        logic [PHASE_W-1:0] phase;
    } cht_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] combo_keys;
        logic [CFG_W-1:0] hold_samples;
        logic [CFG_W-1:0] release_samples;
    } cht_cfg_t;

endpackage

// File: src/combo_hold_trigger_with_rearm_top.sv
// Top level: combination hold trigger with release lockout and re-arm.
`timescale 1ns / 1ps
// Usage
//   s_* channel: one transfer per polled key word (kind = 0) or per task-done
//   event (kind = 1). m_* channel: exactly one result per input transfer,
//   in order: fire (hold completed, launch now) and phase (mode after the item:
//   0 idle, 1 arming, 2 busy, 3 release wait).
//   cfg_*: plain write port, register written at the edge where cfg_wr_en is
//   high; index 0 combination key mask, 1 hold_samples, 2 release_samples,
//   3 ignored. Write only while no item is in flight.
// Timing
//   An item enters the input register at its transfer edge; the state step
//   runs once the result register is free or emptying, and loads the result
//   register, which drives m_valid; the result then waits there for m_ready.
//   One item per cycle is sustained while m_ready stays high: the only loop
//   is the mode/counter update.
// Reset and stall
//   aresetn (synchronous, active low) empties both registers, restores the
//   register defaults (mask keys 0 and 5, hold 30, release 20) and returns to
//   idle. While m_ready is low the result is held; the input register still
//   takes one more transfer, after which s_ready drops until the result moves.
module combo_hold_trigger_with_rearm_top #(
    parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = cht_pkg::COUNT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  cht_pkg::cht_in_t        s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output cht_pkg::cht_out_t       m_data,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_addr,
    input  logic [cht_pkg::CFG_W-1:0] cfg_wdata
);
    import cht_pkg::*;

    cht_cfg_t cfg_reg;
    cht_in_t  in_data_reg;
    logic     in_valid_reg;
    cht_out_t out_data_reg;
    logic     out_valid_reg;
    cht_out_t result;
    logic     advance;
    logic     step;

    // result register free, or emptying this cycle
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.combo_keys      <= COMBO_KEYS_RST;
            cfg_reg.hold_samples    <= HOLD_SAMPLES_RST;
            cfg_reg.release_samples <= RELEASE_SAMPLES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_COMBO_KEYS:      cfg_reg.combo_keys      <= cfg_wdata;
                CFG_HOLD_SAMPLES:    cfg_reg.hold_samples    <= cfg_wdata;
                CFG_RELEASE_SAMPLES: cfg_reg.release_samples <= cfg_wdata;
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    cht_core #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a pending item is never dropped while the result stage is blocked
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending input lost under stall");

    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a full pipeline");

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (out_valid_reg && out_data_reg == $past(result)))
        else $error("result stage missed a step");

    a_fire_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.fire) |-> (out_data_reg.phase == PHASE_BUSY))
        else $error("fire reported outside busy phase");

endmodule

// File: src/cht_core.sv
// Trigger state: mode, sample counter and release tracking, one step per item.
`timescale 1ns / 1ps
module cht_core #(
    parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = cht_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  cht_pkg::cht_in_t  item,
    input  cht_pkg::cht_cfg_t cfg,
    output cht_pkg::cht_out_t result
);
    import cht_pkg::*;

    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [PHASE_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ARMING  = 2'd1,
        MODE_BUSY    = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  seen_reg, seen_next;

    logic [KB-1:0]         mask_k;
    logic [KB-1:0]         hit_k;
    logic                  combo;
    logic                  any_key;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] rel_count;
    logic                  fire;

    assign mask_k    = cfg.combo_keys[KB-1:0];
    assign hit_k     = item.keys[KB-1:0] & mask_k;
    assign combo     = (hit_k == mask_k);
    assign any_key   = |hit_k;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    // released sample straight after a pressed one restarts the run
    assign rel_count = seen_reg ? '0 : count_inc;

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        fire       = 1'b0;
        if (item.kind == KIND_DONE) begin
            if (mode_reg == MODE_BUSY) begin
                mode_next  = MODE_RELEASE;
                count_next = '0;
                seen_next  = 1'b1;
            end
        end else begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (combo) begin
                        mode_next  = MODE_ARMING;
                        count_next = '0;
                    end
                end
                MODE_ARMING: begin
                    if (!combo) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        count_next = count_inc;
                        if (CW'(count_inc) >= CW'(cfg.hold_samples)) begin
                            fire      = 1'b1;
                            mode_next = MODE_BUSY;
                        end
                    end
                end
                MODE_RELEASE: begin
                    if (any_key) begin
                        seen_next  = 1'b1;
                        count_next = '0;
                    end else begin
                        seen_next  = 1'b0;
                        count_next = rel_count;
                        if (CW'(rel_count) >= CW'(cfg.release_samples)) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    // busy: samples ignored
                end
            endcase
        end
    end

    assign result.fire  = fire;
    assign result.phase = mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    // fire only leaves arming, and always lands in busy
    a_fire_from_arming: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && fire) |-> (mode_reg == MODE_ARMING))
        else $error("fire outside arming");

    a_fire_to_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && fire) |=> (mode_reg == MODE_BUSY))
        else $error("fire did not enter busy");

    a_busy_ignores_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_reg == MODE_BUSY && item.kind == KIND_SAMPLE) |=>
            (mode_reg == MODE_BUSY && $stable(count_reg)))
        else $error("sample disturbed busy state");

    a_done_enters_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_reg == MODE_BUSY && item.kind == KIND_DONE) |=>
            (mode_reg == MODE_RELEASE && seen_reg && count_reg == '0))
        else $error("done event mishandled");

endmodule

// File: sim/combo_hold_trigger_with_rearm_top_test.sv
// Testbench: combination hold trigger checked against its own trigger/lockout predictor.
`timescale 1ns / 1ps
module combo_hold_trigger_with_rearm_top_test;

    import cht_pkg::*;

    // run guard in clock cycles
    localparam int CYCLE_LIMIT = 1_000_000;
    // register index beyond the map, must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // cap on a held or released run when hold_samples or release_samples is huge
    localparam int RUN_CAP = 40;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_ARMING  = 2'd1,
        PH_BUSY    = 2'd2,
        PH_RELEASE = 2'd3
    } trig_phase_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    cht_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cht_out_t m_data;

    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_addr  = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    combo_hold_trigger_with_rearm_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of the registers and of the trigger state.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] trig_mask    = COMBO_KEYS_RST;
    logic [CFG_W-1:0] hold_len     = HOLD_SAMPLES_RST;
    logic [CFG_W-1:0] release_len  = RELEASE_SAMPLES_RST;

    trig_phase_t      trig_mode    = PH_IDLE;
    logic [15:0]      sample_cnt   = '0;
    logic             saw_press    = 1'b0;

    // transfers waiting to be offered, and results still owed by the block
    cht_in_t  pending_items[$];
    cht_out_t owed_results[$];

    // idling bounds for the current stretch, 0 gives back-to-back traffic
    int send_gap_max = 6;
    int recv_stall_max = 6;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_fires    = 0;
    int n_settings = 1;
    int n_cycles   = 0;

    function automatic logic [15:0] count_sat(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    // One step of the trigger: advances the predictor state and returns
    // what the block has to report for this transfer.
    function automatic cht_out_t step_trigger(cht_in_t item);
        logic [15:0] held;
        logic        combo;
        logic        some_key;
        cht_out_t    res;
        held     = item.keys & trig_mask;
        combo    = (held == trig_mask);   // empty mask: always held
        some_key = (held != '0);          // empty mask: always released
        res.fire = 1'b0;
        if (item.kind == KIND_DONE) begin
            // done outside busy leaves everything alone
            if (trig_mode == PH_BUSY) begin
                trig_mode  = PH_RELEASE;
                sample_cnt = '0;
                saw_press  = 1'b1;
            end
        end else begin
            case (trig_mode)
                PH_IDLE: begin
                    if (combo) begin
                        trig_mode  = PH_ARMING;
                        sample_cnt = '0;
                    end
                end
                PH_ARMING: begin
                    if (!combo) begin
                        trig_mode = PH_IDLE;
                    end else begin
                        sample_cnt = count_sat(sample_cnt);
                        if (sample_cnt >= hold_len) begin
                            res.fire  = 1'b1;
                            trig_mode = PH_BUSY;
                        end
                    end
                end
                PH_RELEASE: begin
                    if (some_key) begin
                        saw_press  = 1'b1;
                        sample_cnt = '0;
                    end else begin
                        // first released sample after a press restarts the run
                        if (saw_press) begin
                            sample_cnt = '0;
                            saw_press  = 1'b0;
                        end else begin
                            sample_cnt = count_sat(sample_cnt);
                        end
                        if (sample_cnt >= release_len)
                            trig_mode = PH_IDLE;
                    end
                end
                default: ; // busy: samples are ignored
            endcase
        end
        res.phase = trig_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items, predicts each one at its transfer.
    // ------------------------------------------------------------------
    int send_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_results.push_back(step_trigger(s_data));
                n_accepted++;
            end
            // slot free after this edge: either idle or just transferred
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    s_valid   <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_items.size() != 0) begin
                    s_data    <= pending_items.pop_front();
                    s_valid   <= 1'b1;
                    send_wait <= $urandom_range(0, send_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest owed one,
    // then stalls the result side for a drawn number of cycles.
    // ------------------------------------------------------------------
    int recv_wait = 0;

    always @(posedge aclk) begin
        cht_out_t want;
        int       stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = recv_wait;
            if (m_valid && m_ready) begin
                n_results++;
                if (m_data.fire === 1'b1)
                    n_fires++;
                if (owed_results.size() == 0) begin
                    $error("result with nothing owed: fire %0b phase %0d",
                           m_data.fire, m_data.phase);
                    n_errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.fire !== want.fire) begin
                        $error("fire: expected %0b, actual %0b", want.fire, m_data.fire);
                        n_errors++;
                    end
                    if (m_data.phase !== want.phase) begin
                        $error("phase: expected %0d, actual %0d", want.phase, m_data.phase);
                        n_errors++;
                    end
                end
                stall = $urandom_range(0, recv_stall_max);
            end
            if (stall != 0) begin
                m_ready   <= 1'b0;
                recv_wait <= stall - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", n_cycles,
                     owed_results.size());
            $display("combo_hold_trigger_with_rearm_top_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(input logic [KEY_W-1:0] keys);
        cht_in_t item;
        item.kind = KIND_SAMPLE;
        item.keys = keys;
        pending_items.push_back(item);
    endtask

    task automatic queue_done();
        cht_in_t item;
        item.kind = KIND_DONE;
        item.keys = KEY_W'($urandom);   // don't-care bits still toggle
        pending_items.push_back(item);
    endtask

    // Drives a register write after a rising edge; the predictor copy moves at
    // once, ahead of the edge that writes the register. Only called with nothing in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_COMBO_KEYS:      trig_mask   = val;
            CFG_HOLD_SAMPLES:    hold_len    = val;
            CFG_RELEASE_SAMPLES: release_len = val;
            default: ;
        endcase
    endtask

    // Hold the sender until every owed result has arrived, plus a margin
    // for the two-stage pipe.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || owed_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] mask, input logic [CFG_W-1:0] hold,
                            input logic [CFG_W-1:0] rel, input int sgap, input int rgap);
        wait_drained();
        write_reg(CFG_COMBO_KEYS, mask);
        write_reg(CFG_HOLD_SAMPLES, hold);
        write_reg(CFG_RELEASE_SAMPLES, rel);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        send_gap_max   = sgap;
        recv_stall_max = rgap;
        n_settings++;
        @(negedge aclk);
    endtask

    // One press/launch/release cycle with random content, sometimes broken.
    task automatic queue_episode();
        logic [KEY_W-1:0] low_bit;
        int               n;
        low_bit = trig_mask & (~trig_mask + 16'd1);
        // noise, with stray done events
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) queue_done();
            else queue_sample(KEY_W'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
            return;   // pure noise episode
        // hold the combination, occasionally broken or cut short
        n = ((hold_len > RUN_CAP) ? RUN_CAP : int'(hold_len)) + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(0, n);
        repeat (n + 1) queue_sample(trig_mask | KEY_W'($urandom));
        if ($urandom_range(0, 5) == 0)
            queue_sample(KEY_W'($urandom) & ~low_bit);
        // while busy: ignored samples, then the done event
        n = $urandom_range(0, 3);
        repeat (n) queue_sample(KEY_W'($urandom));
        queue_done();
        // release phase: some presses, then a released run
        n = $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                queue_sample(KEY_W'($urandom) | low_bit);
            else
                queue_sample(KEY_W'($urandom) & ~trig_mask);
            if ($urandom_range(0, 9) == 0) queue_done();
        end
        n = ((release_len >= RUN_CAP) ? RUN_CAP : int'(release_len) + 1)
            + $urandom_range(0, 2);
        if ($urandom_range(0, 6) == 0)
            n = $urandom_range(0, n);
        repeat (n) queue_sample(KEY_W'($urandom) & ~trig_mask);
    endtask

    task automatic queue_random(input int quota);
        int target;
        target = pending_items.size() + quota;
        while (pending_items.size() < target)
            queue_episode();
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset values (mask keys 0 and 5, hold 30, release 20):
        // done while idle, empty word, full word arms, hold, break, done again.
        queue_done();
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0021);
        queue_sample(16'h0020);
        queue_done();

        // Directed, short waits. Unmapped index written with junk on the way.
        wait_drained();
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        write_reg(CFG_COMBO_KEYS, 16'h8001);
        write_reg(CFG_HOLD_SAMPLES, 16'd1);
        write_reg(CFG_RELEASE_SAMPLES, 16'd2);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
        @(negedge aclk);
        queue_sample(16'h8001);   // arm
        queue_done();             // done while arming: ignored
        queue_sample(16'hFFFF);   // hold complete: fire
        queue_sample(16'h0000);   // busy: ignored
        queue_sample(16'hFFFF);
        queue_done();             // into release wait
        queue_sample(16'h0001);   // any mask key counts as pressed
        queue_sample(16'h0000);   // first release after a press restarts
        queue_sample(16'h7FFE);   // unmasked keys count as released
        queue_done();             // done while in release wait: ignored
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        queue_sample(16'h0000);
        queue_sample(16'h0000);   // run long enough: back to idle

        // Random, back to the reset values, full idling on both sides.
        set_regs(COMBO_KEYS_RST, HOLD_SAMPLES_RST, RELEASE_SAMPLES_RST, 6, 6);
        queue_random(250);

        // Random mask, short waits, no idling at all.
        set_regs(CFG_W'($urandom_range(1, 16'hFFFF)), CFG_W'($urandom_range(0, 5)),
                 CFG_W'($urandom_range(0, 5)), 0, 0);
        queue_random(250);

        // Empty mask, zero waits: always held and always released.
        set_regs('0, '0, '0, 6, 0);
        queue_random(200);

        // Every key in the mask, release wait that never ends within the run.
        set_regs(16'hFFFF, CFG_W'($urandom_range(1, 8)), 16'hFFFF, 0, 6);
        queue_random(200);

        // Long hold: one key held well past the random episodes' cap, then
        // an instant re-arm. Streamed without gaps.
        set_regs(16'd1 << $urandom_range(0, 15), CFG_W'($urandom_range(60, 120)), '0, 0, 0);
        begin
            logic [KEY_W-1:0] key;
            key = trig_mask;
            queue_sample(key);
            repeat (int'(hold_len)) queue_sample(key | KEY_W'($urandom));
            queue_sample(16'h0000);   // busy
            queue_done();
            queue_sample(~key);       // released: idle at once
        end

        // Random mask and short waits again, full idling.
        set_regs(CFG_W'($urandom), CFG_W'($urandom_range(0, 10)),
                 CFG_W'($urandom_range(0, 10)), 6, 6);
        queue_random(250);

        // Pressure: sender halts until the pipe is empty before finishing.
        wait_drained();
        repeat (10) @(negedge aclk);
        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            n_errors++;
        end

        $display("%0d transfers in, %0d results checked, %0d launches, %0d register settings",
                 n_accepted, n_results, n_fires, n_settings);
        $display("covered idle/arming/busy/release paths, empty and full masks, holds to 120");
        if (n_errors == 0) begin
            $display("combo_hold_trigger_with_rearm_top_test: PASS");
        end else begin
            $display("combo_hold_trigger_with_rearm_top_test: FAIL");
        end
        $finish;
    end

endmodule

// File: combo_hold_trigger_with_rearm_top.f
src/cht_pkg.sv
src/cht_core.sv
src/combo_hold_trigger_with_rearm_top.sv
sim/combo_hold_trigger_with_rearm_top_test.sv
